// ===== sv/rme_pkg.sv =====
// Shared types and constants for the RSA modular exponentiation block.
// No dependencies; used by rme_modmul and rsa_modular_exponentiation.
`default_nettype none

package rme_pkg;

  // Fixed port widths
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned MSG_BITS       = 32;
  localparam int unsigned RESULT_BITS    = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS          = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PUBLIC_EXPONENT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRIVATE_EXPONENT = 2'd2;

  // Opcodes carried in tuser
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Exponentiation sequencer
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_REDUCE,
    SEQ_STEP,
    SEQ_MUL_ACC,
    SEQ_SQUARE,
    SEQ_FINISH
  } seq_state_t;

  // Modular multiplier
  typedef enum logic [0:0] {
    MM_IDLE,
    MM_REDUCE
  } mm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

`default_nettype wire

// ===== sv/rme_modmul.sv =====
// Shared modular multiplier: one registered multiply, then a restoring
// shift-subtract reduction, one product bit per cycle. Uses rme_pkg.
`default_nettype none

module rme_modmul #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [WORD_BITS-1:0]   a,
  input  wire logic [WORD_BITS-1:0]   b,
  input  wire logic [WORD_BITS-1:0]   n,
  output rme_pkg::mm_status_t         status,
  output logic      [WORD_BITS-1:0]   result
);

  localparam int unsigned CW = $clog2(WORD_BITS);

  rme_pkg::mm_state_t state;
  logic [CW-1:0]          count;
  logic [WORD_BITS-1:0]   rem;
  logic [WORD_BITS-1:0]   low;
  logic                   done;

  logic [2*WORD_BITS-1:0] product;
  logic [WORD_BITS:0]     trial;
  logic [WORD_BITS:0]     diff;
  logic                   fits;

  // Operands are below n (or a times one), so the high half starts below n
  assign product = {{WORD_BITS{1'b0}}, a} * {{WORD_BITS{1'b0}}, b};
  assign trial   = {rem, low[WORD_BITS-1]};
  assign diff    = trial - {1'b0, n};
  assign fits    = (trial >= {1'b0, n});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rme_pkg::MM_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        rme_pkg::MM_IDLE: begin
          if (start) begin
            state <= rme_pkg::MM_REDUCE;
            count <= '0;
          end
        end
        rme_pkg::MM_REDUCE: begin
          count <= count + 1'b1;
          if (count == CW'(WORD_BITS - 1)) begin
            state <= rme_pkg::MM_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= rme_pkg::MM_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == rme_pkg::MM_IDLE) begin
      if (start) begin
        rem <= product[2*WORD_BITS-1:WORD_BITS];
        low <= product[WORD_BITS-1:0];
      end
    end else begin
      rem <= fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      low <= {low[WORD_BITS-2:0], 1'b0};
    end
  end

  assign status.busy = (state != rme_pkg::MM_IDLE);
  assign status.done = done;
  assign result      = rem;

endmodule

`default_nettype wire

// ===== sv/rsa_modular_exponentiation.sv =====
// Top level: config registers, square-and-multiply sequencer, output register.
// Depends on rme_pkg and rme_modmul.
//
//  channel   | dir | tdata / fields            | tuser
//  s_axis    | in  | message [31:0]            | opcode [0]
//  m_axis    | out | result [31:0]             | -
//  cfg       | in  | cfg_index selects, cfg_data [31:0] written when cfg_wr_en
//
// An item runs the message once through the shared modular multiplier to reduce it
// mod n, then k multiplies and squarings of the exponent (at most 2*WORD_BITS-1).
// The shared modular multiplier's reduction yields one product bit per cycle.
// Input is taken only while the sequencer is idle; a result waits in the output
// register and the next item is taken while it waits.
// rst is synchronous; it loads modulus 2 and both exponents 1.
`default_nettype none

module rsa_modular_exponentiation #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [rme_pkg::MSG_BITS-1:0]       s_axis_tdata,   // [31:0] message
  input  wire logic                               s_axis_tuser,   // [0] opcode
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [rme_pkg::RESULT_BITS-1:0]    m_axis_tdata,   // [31:0] result
  input  wire logic                               cfg_wr_en,
  input  wire logic [rme_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [rme_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] public_exponent;
  logic [WORD_BITS-1:0] private_exponent;

  rme_pkg::seq_state_t state, state_next;
  logic [WORD_BITS-1:0] base, base_next;
  logic [WORD_BITS-1:0] acc, acc_next;
  logic [WORD_BITS-1:0] expo, expo_next;
  logic                 out_load;

  logic                 mm_start;
  logic [WORD_BITS-1:0] mm_a;
  logic [WORD_BITS-1:0] mm_b;
  logic [WORD_BITS-1:0] mm_result;
  rme_pkg::mm_status_t  mm_status;

  logic                 in_beat;
  logic [WORD_BITS-1:0] sel_expo;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= WORD_BITS'(2);
      public_exponent  <= WORD_BITS'(1);
      private_exponent <= WORD_BITS'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rme_pkg::REG_MODULUS:          modulus          <= cfg_data[WORD_BITS-1:0];
        rme_pkg::REG_PUBLIC_EXPONENT:  public_exponent  <= cfg_data[WORD_BITS-1:0];
        rme_pkg::REG_PRIVATE_EXPONENT: private_exponent <= cfg_data[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == rme_pkg::SEQ_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign sel_expo      = (s_axis_tuser == rme_pkg::OP_DECRYPT) ? private_exponent
                                                               : public_exponent;

  rme_modmul #(
    .WORD_BITS(WORD_BITS)
  ) u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .n      (modulus),
    .status (mm_status),
    .result (mm_result)
  );

  always_comb begin
    state_next = state;
    base_next  = base;
    acc_next   = acc;
    expo_next  = expo;
    mm_start   = 1'b0;
    mm_a       = base;
    mm_b       = base;
    out_load   = 1'b0;
    case (state)
      rme_pkg::SEQ_IDLE: begin
        if (in_beat) begin
          base_next = s_axis_tdata[WORD_BITS-1:0];
          expo_next = sel_expo;
          acc_next  = WORD_BITS'(1);
          if (modulus == '0) begin
            acc_next   = '0;
            state_next = rme_pkg::SEQ_FINISH;
          end else if (sel_expo == '0) begin
            state_next = rme_pkg::SEQ_FINISH;
          end else begin
            state_next = rme_pkg::SEQ_LOAD;
          end
        end
      end
      rme_pkg::SEQ_LOAD: begin
        // message mod n first, so every later operand is below n
        mm_start   = 1'b1;
        mm_b       = WORD_BITS'(1);
        state_next = rme_pkg::SEQ_REDUCE;
      end
      rme_pkg::SEQ_REDUCE: begin
        if (mm_status.done) begin
          base_next  = mm_result;
          state_next = rme_pkg::SEQ_STEP;
        end
      end
      rme_pkg::SEQ_STEP: begin
        mm_start = 1'b1;
        if (expo[0]) begin
          mm_a       = acc;
          state_next = rme_pkg::SEQ_MUL_ACC;
        end else begin
          state_next = rme_pkg::SEQ_SQUARE;
        end
      end
      rme_pkg::SEQ_MUL_ACC: begin
        if (mm_status.done) begin
          acc_next  = mm_result;
          expo_next = {expo[WORD_BITS-1:1], 1'b0};
          // last set bit: the trailing square is never used
          state_next = (expo[WORD_BITS-1:1] == '0) ? rme_pkg::SEQ_FINISH
                                                   : rme_pkg::SEQ_STEP;
        end
      end
      rme_pkg::SEQ_SQUARE: begin
        if (mm_status.done) begin
          base_next  = mm_result;
          expo_next  = {1'b0, expo[WORD_BITS-1:1]};
          state_next = rme_pkg::SEQ_STEP;
        end
      end
      rme_pkg::SEQ_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = rme_pkg::SEQ_IDLE;
        end
      end
      default: state_next = rme_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rme_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    base <= base_next;
    acc  <= acc_next;
    expo <= expo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= rme_pkg::RESULT_BITS'(acc);
    end
  end

endmodule

`default_nettype wire

// ===== sv/rme_checker.sv =====
// Port-level checks for rsa_modular_exponentiation, bound to the top level.
// Depends only on rme_pkg widths.
`default_nettype none

module rme_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [rme_pkg::RESULT_BITS-1:0] m_axis_tdata
);

  // A result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped before taken");

  // A stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

  // One item at a time: busy right after an input beat
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // A new result comes only from a busy sequencer
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without work");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind rsa_modular_exponentiation rme_checker u_rme_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
